@@ rtl/tc_pkg.sv @@
// tc_pkg: widths, packing constants and fixed-point helpers for transform_compose
// no dependencies; imported by every tc module
package tc_pkg;

    localparam int IN_W   = 320;
    localparam int OUT_W  = 168;

    // signed 16-bit lane of a packed word
    function automatic logic signed [15:0] lane(input logic [63:0] p, input int idx);
        lane = p[idx*16 +: 16];
    endfunction

    // clamp a wide signed value to 16 bits, raising the flag on overflow
    function automatic logic [16:0] sat16(input logic signed [47:0] v);
        if (v > 48'sd32767)
            sat16 = {1'b1, 16'h7fff};
        else if (v < -48'sd32768)
            sat16 = {1'b1, 16'h8000};
        else
            sat16 = {1'b0, v[15:0]};
    endfunction

endpackage

@@ rtl/tc_mul_stage.sv @@
// tc_mul_stage: first arithmetic stages: scaled child location, scale products,
// quaternion partial products and the first cross product; depends on tc_pkg
module tc_mul_stage
    import tc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [IN_W-1:0]          in_data,
    output logic                     s2_valid,
    output logic signed [15:0]       aw_o,
    output logic signed [15:0]       ax_o,
    output logic signed [15:0]       ay_o,
    output logic signed [15:0]       az_o,
    output logic signed [47:0]       ploc_o [3],
    output logic signed [31:0]       v_o [3],
    output logic signed [33:0]       uv_o [3],
    output logic signed [33:0]       q_o [4],
    output logic signed [31:0]       sc_o [3]
);

    logic                     v1_reg;
    logic signed [15:0]       aw_reg, ax_reg, ay_reg, az_reg;
    logic signed [15:0]       bw_reg, bx_reg, by_reg, bz_reg;
    logic signed [15:0]       ploc_reg [3];
    logic signed [31:0]       v_reg [3];
    logic signed [31:0]       sc_reg [3];
    logic signed [15:0]       pl [3];
    logic signed [15:0]       ps [3];
    logic signed [15:0]       cl [3];
    logic signed [15:0]       cs [3];
    logic [63:0]              pr, cr;

    // unpack the word, x on top
    always_comb
    begin
        pr = in_data[111:48];
        cr = in_data[271:208];
        for (int i = 0; i < 3; i++)
        begin
            pl[i] = lane({16'h0, in_data[47:0]}, 2 - i);
            ps[i] = lane({16'h0, in_data[159:112]}, 2 - i);
            cl[i] = lane({16'h0, in_data[207:160]}, 2 - i);
            cs[i] = lane({16'h0, in_data[319:272]}, 2 - i);
        end
    end

    // stage 1: per-axis products
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aw_reg <= lane(pr, 3); ax_reg <= lane(pr, 2);
            ay_reg <= lane(pr, 1); az_reg <= lane(pr, 0);
            bw_reg <= lane(cr, 3); bx_reg <= lane(cr, 2);
            by_reg <= lane(cr, 1); bz_reg <= lane(cr, 0);
            for (int i = 0; i < 3; i++)
            begin
                ploc_reg[i] <= pl[i];
                v_reg[i]    <= ps[i] * cl[i];
                sc_reg[i]   <= ps[i] * cs[i];
            end
        end
    end

    // stage 2: quaternion products and first cross product
    logic                     v2_reg;
    logic signed [15:0]       aw2_reg, ax2_reg, ay2_reg, az2_reg;
    logic signed [47:0]       ploc2_reg [3];
    logic signed [31:0]       v2v_reg [3];
    logic signed [31:0]       sc2_reg [3];
    logic signed [33:0]       q2_reg [4];
    logic signed [33:0]       uv2_reg [3];
    logic signed [52:0]       cx [3];

    always_comb
    begin
        cx[0] = 53'(ay_reg * v_reg[2]) - 53'(az_reg * v_reg[1]);
        cx[1] = 53'(az_reg * v_reg[0]) - 53'(ax_reg * v_reg[2]);
        cx[2] = 53'(ax_reg * v_reg[1]) - 53'(ay_reg * v_reg[0]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            aw2_reg <= aw_reg; ax2_reg <= ax_reg; ay2_reg <= ay_reg; az2_reg <= az_reg;
            q2_reg[0] <= 34'(aw_reg*bw_reg) - 34'(ax_reg*bx_reg) - 34'(ay_reg*by_reg)
                       - 34'(az_reg*bz_reg);
            q2_reg[1] <= 34'(aw_reg*bx_reg) + 34'(ax_reg*bw_reg) + 34'(ay_reg*bz_reg)
                       - 34'(az_reg*by_reg);
            q2_reg[2] <= 34'(aw_reg*by_reg) - 34'(ax_reg*bz_reg) + 34'(ay_reg*bw_reg)
                       + 34'(az_reg*bx_reg);
            q2_reg[3] <= 34'(aw_reg*bz_reg) + 34'(ax_reg*by_reg) - 34'(ay_reg*bx_reg)
                       + 34'(az_reg*bw_reg);
            for (int i = 0; i < 3; i++)
            begin
                ploc2_reg[i] <= 48'(ploc_reg[i]);
                v2v_reg[i]   <= v_reg[i];
                sc2_reg[i]   <= sc_reg[i];
                // round to Q.20, ties up
                uv2_reg[i]   <= 34'((cx[i] + 53'sd8192) >>> 14);
            end
        end
    end

    assign s2_valid = v2_reg;
    assign aw_o = aw2_reg;
    assign ax_o = ax2_reg;
    assign ay_o = ay2_reg;
    assign az_o = az2_reg;
    assign ploc_o = ploc2_reg;
    assign v_o = v2v_reg;
    assign uv_o = uv2_reg;
    assign q_o = q2_reg;
    assign sc_o = sc2_reg;

endmodule

@@ rtl/tc_sum_stage.sv @@
// tc_sum_stage: second cross product, location sum, rounding and saturation
// depends on tc_pkg; fed by tc_mul_stage
module tc_sum_stage
    import tc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic signed [15:0]       aw,
    input  logic signed [15:0]       ax,
    input  logic signed [15:0]       ay,
    input  logic signed [15:0]       az,
    input  logic signed [47:0]       ploc [3],
    input  logic signed [31:0]       v [3],
    input  logic signed [33:0]       uv [3],
    input  logic signed [33:0]       q [4],
    input  logic signed [31:0]       sc [3],
    output logic                     out_valid,
    output logic [OUT_W-1:0]         out_data
);

    // stage 3: products with the parent rotation
    logic                     v3_reg;
    logic signed [49:0]       wuv_reg [3];
    logic signed [50:0]       uuv_reg [3];
    logic signed [47:0]       base_reg [3];
    logic signed [33:0]       q3_reg [4];
    logic signed [31:0]       sc3_reg [3];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v3_reg <= 1'b0;
        else if (en)
            v3_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            uuv_reg[0] <= 51'(ay*uv[2]) - 51'(az*uv[1]);
            uuv_reg[1] <= 51'(az*uv[0]) - 51'(ax*uv[2]);
            uuv_reg[2] <= 51'(ax*uv[1]) - 51'(ay*uv[0]);
            for (int i = 0; i < 3; i++)
            begin
                wuv_reg[i]  <= 50'(aw * uv[i]);
                base_reg[i] <= (ploc[i] <<< 26) + (48'(v[i]) <<< 14);
            end
            q3_reg  <= q;
            sc3_reg <= sc;
        end
    end

    // stage 4: sums, rounding and clamping
    logic                     v4_reg;
    logic [OUT_W-1:0]         d4_reg;
    logic [16:0]              s [10];
    logic signed [53:0]       lsum;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            lsum = 54'(base_reg[i]) + 54'((54'(wuv_reg[i]) + 54'(uuv_reg[i])) <<< 1);
            s[i] = sat16(48'((lsum + 54'sd33554432) >>> 26));
            s[7+i] = sat16(48'((49'(sc3_reg[i]) + 49'sd2048) >>> 12));
        end
        for (int i = 0; i < 4; i++)
            s[3+i] = sat16(48'((35'(q3_reg[i]) + 35'sd8192) >>> 14));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v4_reg <= 1'b0;
        else if (en)
            v4_reg <= v3_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d4_reg <= {7'b0,
                       s[0][16] | s[1][16] | s[2][16] | s[3][16] | s[4][16] |
                       s[5][16] | s[6][16] | s[7][16] | s[8][16] | s[9][16],
                       s[7][15:0], s[8][15:0], s[9][15:0],
                       s[3][15:0], s[4][15:0], s[5][15:0], s[6][15:0],
                       s[0][15:0], s[1][15:0], s[2][15:0]};
        end
    end

    assign out_valid = v4_reg;
    assign out_data  = d4_reg;

endmodule

@@ rtl/transform_compose_core.sv @@
// transform_compose_core: top level, four-stage compose pipeline with output skid
// depends on tc_pkg, tc_mul_stage, tc_sum_stage
//
// Composes a parent and child transform (location Q8.8, quaternion Q2.14, scale
// Q4.12) into one result word. One word is accepted per cycle; each word passes
// through the four multiply and sum stages in turn, registered at each.
// The pipeline advances while the skid register is empty; a word the sink does
// not take moves into the skid, which holds the pipe until it drains, so
// tready never depends on m_axis_tready combinationally.
module transform_compose_core
    import tc_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // parent_location, parent_rotation, parent_scale, child_location,
    // child_rotation, child_scale
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // out_location, out_rotation, out_scale, saturated, zero pad
    output logic [OUT_W-1:0]  m_axis_tdata
);

    logic                en;
    logic                s2_valid, p_valid;
    logic [OUT_W-1:0]    p_data;
    logic signed [15:0]  aw, ax, ay, az;
    logic signed [47:0]  ploc [3];
    logic signed [31:0]  v [3];
    logic signed [33:0]  uv [3];
    logic signed [33:0]  q [4];
    logic signed [31:0]  sc [3];
    logic                skid_reg;
    logic [OUT_W-1:0]    skid_data_reg;

    // pipeline moves while the skid register is empty
    assign en            = !skid_reg;
    assign s_axis_tready = en;

    tc_mul_stage u_mul (
        .clk(clk), .rst_n(rst_n), .en(en),
        .in_valid(s_axis_tvalid), .in_data(s_axis_tdata),
        .s2_valid(s2_valid), .aw_o(aw), .ax_o(ax), .ay_o(ay), .az_o(az),
        .ploc_o(ploc), .v_o(v), .uv_o(uv), .q_o(q), .sc_o(sc)
    );

    tc_sum_stage u_sum (
        .clk(clk), .rst_n(rst_n), .en(en), .in_valid(s2_valid),
        .aw(aw), .ax(ax), .ay(ay), .az(az),
        .ploc(ploc), .v(v), .uv(uv), .q(q), .sc(sc),
        .out_valid(p_valid), .out_data(p_data)
    );

    // skid catches the word leaving the pipe when the sink stalls
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skid_reg <= 1'b0;
        else if (skid_reg)
            skid_reg <= !m_axis_tready;
        else
            skid_reg <= p_valid && !m_axis_tready;
    end

    always_ff @(posedge clk)
    begin
        if (!skid_reg)
            skid_data_reg <= p_data;
    end

    assign m_axis_tvalid = skid_reg || p_valid;
    assign m_axis_tdata  = skid_reg ? skid_data_reg : p_data;

endmodule
